// ===== hw/rtl/sstl_pkg.sv =====
// Shared types and constants for the smoothed sensor table linearizer.
// Used by the table memory, the serial divider and the top level.
// Depends on nothing.
package sstl_pkg;

	// Table geometry and sample format
	localparam int TABLE_DEPTH = 128;
	localparam int ADC_BITS    = 10;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LVL_W       = 16;
	localparam int DST_W       = 16;

	// Configuration register layout
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;
	localparam int WEIGHT_W    = 9;
	localparam int USED_W      = 8;

	// Interpolation arithmetic widths
	localparam int PROD_W      = 2 * (LVL_W + 1);
	localparam int DIV_W       = PROD_W - 1;
	localparam int QS_W        = DIV_W + 1;
	localparam int RES_W       = QS_W + 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT = CFG_IDX_W'(0),
		REG_USED   = CFG_IDX_W'(1)
	} cfg_reg_t;

	// Word kinds on the input channel
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// One calibration pair as stored in the table
	typedef struct packed {
		logic [DST_W-1:0] distance;
		logic [LVL_W-1:0] level;
	} entry_t;

	// Write side of the table memory
	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] addr;
		entry_t            data;
	} table_wr_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [LVL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/sstl_table.sv =====
// Calibration table memory: one write port, one read port, registered read data.
// Depends on sstl_pkg for the entry and write-port types.
module sstl_table (
	input  logic                      clk,
	input  sstl_pkg::table_wr_t       wr,
	input  logic [sstl_pkg::TBL_AW-1:0] raddr,
	output sstl_pkg::entry_t          rdata
);
	import sstl_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	// Write one pair
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read data is registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sstl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sstl_pkg for the request and response structs.
module sstl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sstl_pkg::div_req_t req,
	output sstl_pkg::div_rsp_t rsp
);
	import sstl_pkg::*;

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  quo_q;
	logic [LVL_W-1:0]  rem_q;
	logic [LVL_W-1:0]  dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [LVL_W:0]    trial;
	logic              fits;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and partial results
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= LVL_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[LVL_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/smoothed_sensor_table_linearizer.sv =====
// Smoothed sensor table linearizer: top level with sequencer and datapath.
// Depends on sstl_pkg, sstl_table and sstl_div.
//
// Usage: a word is accepted on the rising edge where start is high and busy is
// low. kind low loads one calibration pair (entry_distance, entry_level) into
// the table at entry_index; the write happens at the accept edge, busy stays low
// and no result follows. kind high hands in raw_sample: the block updates its
// IIR-smoothed level, scans the table from entry 0 for the first level not above
// it, reads the two segment ends and interpolates with a serial divide.
// The result (distance, out_of_range) is on the outputs for exactly one cycle
// with done high; the receiver cannot hold it off.
// The scan stops at an index no larger than the clamped entries_used minus one. It
// reads one table entry per cycle through the single read port, and the divider
// adds one quotient bit per cycle for a 33-bit quotient. A zero-width segment
// skips the divider. One sample word is in flight at a time; the next word can be
// accepted at the edge that takes the result.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while busy is
// low; the block itself does not enforce it. Reset clears the smoothed level and
// restores the register defaults; the table holds no defined contents until loaded.
module smoothed_sensor_table_linearizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [6:0]                      entry_index,
	input  logic [sstl_pkg::DST_W-1:0]      entry_distance,
	input  logic [sstl_pkg::LVL_W-1:0]      entry_level,
	input  logic [sstl_pkg::ADC_BITS-1:0]   raw_sample,
	input  logic                            cfg_we,
	input  logic [sstl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sstl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output logic [sstl_pkg::DST_W-1:0]      distance,
	output logic                            out_of_range
);
	import sstl_pkg::*;

	localparam int ACC_W = WEIGHT_W + LVL_W;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_SMOOTH   = 10'b00_0000_0010,
		ST_SCAN     = 10'b00_0000_0100,
		ST_RD_HI    = 10'b00_0000_1000,
		ST_RD_LO    = 10'b00_0001_0000,
		ST_CAP_LO   = 10'b00_0010_0000,
		ST_MUL      = 10'b00_0100_0000,
		ST_DIV_GO   = 10'b00_1000_0000,
		ST_DIV_WAIT = 10'b01_0000_0000,
		ST_FINISH   = 10'b10_0000_0000
	} state_t;

	state_t                  state_q;
	logic [WEIGHT_W-1:0]     weight_q;
	logic [USED_W-1:0]       used_q;
	logic [LVL_W-1:0]        smooth_q;
	logic [ACC_W-1:0]        wr_prod_q;
	logic [CNT_W-1:0]        k_q;
	logic                    vld_q;
	logic [TBL_AW-1:0]       hi_q;
	logic                    oor_q;
	logic [DST_W-1:0]        dhi_q;
	logic [LVL_W-1:0]        lhi_q;
	logic [DST_W-1:0]        dlo_q;
	logic [LVL_W-1:0]        llo_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [LVL_W:0]   den_q;
	logic                    neg_q;
	logic signed [QS_W-1:0]  q_q;
	logic                    done_q;
	logic [DST_W-1:0]        dist_q;
	logic                    oor_out_q;

	logic                    accept;
	logic [WEIGHT_W-1:0]     w_eff;
	logic [LVL_W-1:0]        r_sh;
	logic [ACC_W-1:0]        acc;
	logic [CNT_W-1:0]        n_eff;
	logic [CNT_W-1:0]        chk_idx;
	logic [CNT_W-1:0]        hit_idx;
	logic [CNT_W-1:0]        hi_clamp;
	logic                    hit;
	logic                    miss;
	logic signed [LVL_W:0]   ds_a;
	logic signed [DST_W:0]   dd_b;
	logic signed [PROD_W-1:0] prod_c;
	logic [PROD_W-1:0]       prod_abs;
	logic [LVL_W:0]          den_abs;
	logic signed [RES_W-1:0] res;
	logic [TBL_AW-1:0]       raddr;
	table_wr_t               tbl_wr;
	entry_t                  rd;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Clamp the registers to their working ranges
	assign w_eff = (weight_q > WEIGHT_W'(256)) ? WEIGHT_W'(256) : weight_q;
	always_comb begin
		if (32'(used_q) < 32'd2) begin
			n_eff = CNT_W'(2);
		end else if (32'(used_q) > 32'(TABLE_DEPTH)) begin
			n_eff = CNT_W'(TABLE_DEPTH);
		end else begin
			n_eff = CNT_W'(used_q);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_W'(230);
			used_q   <= USED_W'(70);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEIGHT: weight_q <= WEIGHT_W'(cfg_data);
				REG_USED:   used_q   <= USED_W'(cfg_data);
				default:    ;
			endcase
		end
	end

	// Table memory: load words write at the accept edge
	assign tbl_wr.we   = accept && (kind == KIND_LOAD) &&
	                     (32'(entry_index) < 32'(TABLE_DEPTH));
	assign tbl_wr.addr = TBL_AW'(entry_index);
	assign tbl_wr.data = '{distance: entry_distance, level: entry_level};

	always_comb begin
		case (state_q)
			ST_SCAN:  raddr = k_q[TBL_AW-1:0];
			ST_RD_HI: raddr = hi_q;
			ST_RD_LO: raddr = hi_q - 1'b1;
			default:  raddr = hi_q;
		endcase
	end

	sstl_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.raddr (raddr),
		.rdata (rd)
	);

	// Smoothing: new sample term is multiplied at accept, old term in SMOOTH
	assign r_sh = LVL_W'(raw_sample) << (LVL_W - ADC_BITS);
	assign acc  = wr_prod_q + ACC_W'(WEIGHT_W'(256) - w_eff) * ACC_W'(smooth_q);

	// Scan compare on the entry read last cycle
	assign chk_idx  = k_q - 1'b1;
	assign hit      = vld_q && (rd.level <= smooth_q);
	assign miss     = vld_q && !hit && (chk_idx == n_eff - 1'b1);
	assign hit_idx  = hit ? chk_idx : n_eff;
	always_comb begin
		if (hit_idx == '0) begin
			hi_clamp = CNT_W'(1);
		end else if (hit_idx > n_eff - 1'b1) begin
			hi_clamp = n_eff - 1'b1;
		end else begin
			hi_clamp = hit_idx;
		end
	end

	// Interpolation numerator and denominator
	assign ds_a   = $signed({1'b0, smooth_q}) - $signed({1'b0, llo_q});
	assign dd_b   = $signed({1'b0, dhi_q}) - $signed({1'b0, dlo_q});
	assign prod_c = ds_a * dd_b;
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign den_abs  = den_q[LVL_W] ? (LVL_W+1)'(-den_q) : (LVL_W+1)'(den_q);

	assign div_req.start    = (state_q == ST_DIV_GO) && (den_q != '0);
	assign div_req.dividend = prod_abs[DIV_W-1:0];
	assign div_req.divisor  = den_abs[LVL_W-1:0];

	sstl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Final sum before saturation
	assign res = RES_W'(dlo_q) + RES_W'(q_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			smooth_q  <= '0;
			vld_q     <= 1'b0;
			k_q       <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_SAMPLE)) begin
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: begin
					smooth_q <= acc[ACC_W-2:ACC_W-1-LVL_W];
					k_q      <= '0;
					vld_q    <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit || miss) begin
						state_q <= ST_RD_HI;
					end else begin
						k_q   <= k_q + 1'b1;
						vld_q <= 1'b1;
					end
				end
				ST_RD_HI:    state_q <= ST_RD_LO;
				ST_RD_LO:    state_q <= ST_CAP_LO;
				ST_CAP_LO:   state_q <= ST_MUL;
				ST_MUL:      state_q <= ST_DIV_GO;
				ST_DIV_GO: begin
					if (den_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_SAMPLE)) begin
			wr_prod_q <= ACC_W'(w_eff) * ACC_W'(r_sh);
		end
		if (state_q == ST_SCAN && (hit || miss)) begin
			hi_q  <= TBL_AW'(hi_clamp);
			oor_q <= miss || (hit && chk_idx == '0 && rd.level < smooth_q);
		end
		if (state_q == ST_RD_LO) begin
			dhi_q <= rd.distance;
			lhi_q <= rd.level;
		end
		if (state_q == ST_CAP_LO) begin
			dlo_q <= rd.distance;
			llo_q <= rd.level;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
			den_q  <= $signed({1'b0, lhi_q}) - $signed({1'b0, llo_q});
		end
		if (state_q == ST_DIV_GO) begin
			q_q   <= '0;
			neg_q <= prod_q[PROD_W-1] ^ den_q[LVL_W];
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			q_q <= neg_q ? -$signed({1'b0, div_rsp.quotient})
			             : $signed({1'b0, div_rsp.quotient});
		end
		if (state_q == ST_FINISH) begin
			if (res < 0) begin
				dist_q    <= '0;
				oor_out_q <= 1'b1;
			end else if (res > RES_W'(65535)) begin
				dist_q    <= '1;
				oor_out_q <= 1'b1;
			end else begin
				dist_q    <= res[DST_W-1:0];
				oor_out_q <= oor_q;
			end
		end
	end

	assign done         = done_q;
	assign distance     = dist_q;
	assign out_of_range = oor_out_q;

	// Result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");

	// A result appears only once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// A load word never starts the sequencer or makes a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_LOAD)) |=> (!busy && !done))
		else $error("load word caused activity");

	// Divider finishes only while the sequencer waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

endmodule

// ===== tb/smoothed_sensor_table_linearizer_tb.sv =====
// Testbench for the smoothed sensor table linearizer: directed tests, then random phases.
// Predicts every sample word in-line and checks each done strobe in order.
// Depends on sstl_pkg and the smoothed_sensor_table_linearizer RTL.
module smoothed_sensor_table_linearizer_tb;
	import sstl_pkg::*;

	localparam int   SETTLE_CYCLES = 200;
	localparam int   LIMIT_TIME    = 50_000_000;
	localparam int   PHASES        = 8;
	localparam int   PHASE_WORDS   = 150;

	typedef struct packed {
		logic [DST_W-1:0] distance;
		logic             out_of_range;
	} dist_result_t;

	logic                  clk;
	logic                  arst_n         = 1'b0;
	logic                  start          = 1'b0;
	logic                  busy;
	logic                  kind           = KIND_LOAD;
	logic [6:0]            entry_index    = '0;
	logic [DST_W-1:0]      entry_distance = '0;
	logic [LVL_W-1:0]      entry_level    = '0;
	logic [ADC_BITS-1:0]   raw_sample     = '0;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	logic                  done;
	logic [DST_W-1:0]      distance;
	logic                  out_of_range;

	// Shadow of the block: calibration table, IIR level and registers
	logic [DST_W-1:0] cal_distance [TABLE_DEPTH];
	logic [LVL_W-1:0] cal_level [TABLE_DEPTH];
	logic [LVL_W-1:0] iir_level  = '0;
	logic [8:0]       weight_reg = 9'd230;
	logic [7:0]       used_reg   = 8'd70;

	dist_result_t pending_distances [$];

	bit gaps_on = 1'b1;
	int words_sent = 0;
	int loads_sent = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int lost_results = 0;
	int band_top = 65535;
	int band_bot = 0;

	smoothed_sensor_table_linearizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.entry_index   (entry_index),
		.entry_distance(entry_distance),
		.entry_level   (entry_level),
		.raw_sample    (raw_sample),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.distance      (distance),
		.out_of_range  (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the IIR level, then look up and interpolate the segment
	function automatic dist_result_t linearize_sample(input logic [ADC_BITS-1:0] raw);
		logic [31:0]  acc;
		logic [31:0]  w;
		int unsigned  n;
		int unsigned  seg;
		longint       s, llo, lhi, dlo, dhi, den, res;
		logic         oor;
		dist_result_t r;
		w = (weight_reg > 9'd256) ? 32'd256 : 32'(weight_reg);
		acc = w * 32'({raw, 6'b0}) + (32'd256 - w) * 32'(iir_level);
		iir_level = acc[23:8];
		n = (used_reg < 8'd2) ? 2 : ((used_reg > 8'd128) ? 128 : used_reg);
		s = iir_level;
		// first entry whose level is not above the smoothed level
		seg = n;
		for (int k = n - 1; k >= 0; k--)
			if (cal_level[k] <= s)
				seg = k;
		oor = (seg == n) || (seg == 0 && cal_level[0] < s);
		if (seg < 1)
			seg = 1;
		if (seg > n - 1)
			seg = n - 1;
		llo = cal_level[seg-1];
		lhi = cal_level[seg];
		dlo = cal_distance[seg-1];
		dhi = cal_distance[seg];
		den = lhi - llo;
		if (den == 0)
			res = dlo;
		else
			res = dlo + ((s - llo) * (dhi - dlo)) / den;
		if (res < 0) begin
			res = 0;
			oor = 1'b1;
		end
		if (res > 65535) begin
			res = 65535;
			oor = 1'b1;
		end
		r.distance = res[15:0];
		r.out_of_range = oor;
		return r;
	endfunction

	// Check every done strobe against the oldest expected distance
	always @(posedge clk) begin : check_distances
		dist_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_distances.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result distance %h out_of_range %b",
						$time, distance, out_of_range);
				mismatches++;
			end else begin
				want = pending_distances.pop_front();
				if (want.distance !== distance || want.out_of_range !== out_of_range) begin
					if (mismatches < 10)
						$display("%0t: distance exp %h got %h, out_of_range exp %b got %b",
							$time, want.distance, distance, want.out_of_range, out_of_range);
					mismatches++;
				end
			end
		end
	end

	// Hand one word to the block; start stays high after the accept edge
	task automatic send_word(input logic k, input logic [6:0] idx, input logic [DST_W-1:0] d,
		input logic [LVL_W-1:0] l, input logic [ADC_BITS-1:0] raw);
		if (gaps_on)
			while ($urandom_range(99) < 17) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		kind <= k;
		entry_index <= idx;
		entry_distance <= d;
		entry_level <= l;
		raw_sample <= raw;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (k == KIND_LOAD) begin
			cal_distance[idx] = d;
			cal_level[idx] = l;
			loads_sent++;
		end else begin
			pending_distances.push_back(linearize_sample(raw));
			samples_sent++;
		end
		words_sent++;
	endtask

	task automatic load_entry(input logic [6:0] idx, input logic [DST_W-1:0] d,
		input logic [LVL_W-1:0] l);
		send_word(KIND_LOAD, idx, d, l, ADC_BITS'($urandom_range(1023)));
	endtask

	task automatic take_sample(input logic [ADC_BITS-1:0] raw);
		send_word(KIND_SAMPLE, 7'($urandom_range(127)), DST_W'($urandom), LVL_W'($urandom), raw);
	endtask

	// Drop start, drain all results, then let the block settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_distances.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		if (r == REG_WEIGHT)
			weight_reg = v;
		else
			used_reg = v[7:0];
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Load entries 0..n-1 with a falling level ramp and random distances
	task automatic fill_table(input int n);
		int     k;
		int     dir;
		longint span, lvl, dst;
		band_top = $urandom_range(65535, 8000);
		band_bot = $urandom_range(band_top - 1, 0);
		span = band_top - band_bot;
		dst = $urandom_range(30000, 0);
		dir = ($urandom_range(99) < 15) ? -1 : 1;
		lvl = band_top;
		for (k = 0; k < n; k++) begin
			// repeat the previous level now and then for a flat segment
			if (k > 0 && $urandom_range(9) != 0)
				lvl = band_top - (span * k) / (n - 1);
			if (k > 0)
				dst = dst + dir * longint'($urandom_range(60000 / n, 0));
			if (dst < 0)
				dst = 0;
			if (dst > 65535)
				dst = 65535;
			load_entry(7'(k), DST_W'(dst), LVL_W'(lvl));
		end
	endtask

	task automatic test_table_fill();
		for (int k = 0; k < TABLE_DEPTH; k++)
			load_entry(7'(k), DST_W'(1000 + k * 400), LVL_W'(65472 - k * 500));
	endtask

	task automatic test_reset_defaults();
		take_sample(10'd0);
		take_sample(10'd512);
		take_sample(10'd1023);
	endtask

	task automatic test_register_extremes();
		set_reg(REG_WEIGHT, 9'd256);
		set_reg(REG_USED, 9'd128);
		take_sample(10'd1023);
		take_sample(10'd0);
		take_sample(10'd1);
		// entry counts below two and above the table depth
		set_reg(REG_USED, 9'd0);
		take_sample(10'd512);
		set_reg(REG_USED, 9'd1);
		take_sample(10'd300);
		set_reg(REG_USED, 9'd255);
		take_sample(10'd0);
		// zero weight freezes the level, weights above 256 act as 256
		set_reg(REG_WEIGHT, 9'd0);
		take_sample(10'd1023);
		set_reg(REG_WEIGHT, 9'd511);
		take_sample(10'd700);
		set_reg(REG_WEIGHT, 9'd300);
		take_sample(10'd100);
	endtask

	task automatic test_segment_cases();
		set_reg(REG_WEIGHT, 9'd256);
		set_reg(REG_USED, 9'd4);
		load_entry(7'd0, 16'd100, 16'd60000);
		load_entry(7'd1, 16'd20000, 16'd59000);
		load_entry(7'd2, 16'd30000, 16'd2000);
		load_entry(7'd3, 16'hFFFF, 16'd1000);
		// above the first level, below the last level, inside the table
		take_sample(10'd1023);
		take_sample(10'd0);
		take_sample(10'd500);
		// flat last segment reached by extrapolation
		load_entry(7'd2, 16'd30000, 16'd1000);
		take_sample(10'd0);
		// flat first segment: exact hit, then just above it
		load_entry(7'd0, 16'd5000, 16'd40960);
		load_entry(7'd1, 16'd9000, 16'd40960);
		take_sample(10'd640);
		take_sample(10'd641);
		// field extremes outside the entries in use
		load_entry(7'd127, 16'hFFFF, 16'h0000);
		load_entry(7'd126, 16'h0000, 16'hFFFF);
	endtask

	task automatic test_random_phases();
		int weights [PHASES] = '{230, 256, 20, 511, 128, 256, 180, 96};
		int counts [PHASES]  = '{70, 2, 128, 9, 3, 16, 128, 33};
		int n;
		int target;
		int pick;
		for (int p = 0; p < PHASES; p++) begin
			set_reg(REG_WEIGHT, CFG_DATA_W'(weights[p]));
			set_reg(REG_USED, CFG_DATA_W'(counts[p]));
			gaps_on = (p != 5);
			n = (counts[p] < 2) ? 2 : ((counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : counts[p]);
			fill_table(n);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 8)
					load_entry(7'($urandom_range(127)), DST_W'($urandom), LVL_W'($urandom));
				else if (pick < 11 && n <= 16)
					fill_table(n);
				else if (pick < 80)
					take_sample(ADC_BITS'($urandom_range(band_top >> 6, band_bot >> 6)));
				else
					take_sample(ADC_BITS'($urandom_range(1023)));
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_table_fill();
		test_reset_defaults();
		test_register_extremes();
		test_segment_cases();
		test_random_phases();
		wait_idle();
		lost_results = pending_distances.size();
		if (lost_results != 0)
			$display("%0d expected results never arrived", lost_results);
		$display("Covered %0d table loads and %0d samples over %0d register writes",
			loads_sent, samples_sent, reg_writes);
		$display("Checked %0d results, %0d mismatched", results_seen, mismatches);
		if (mismatches == 0 && lost_results == 0)
			$display("smoothed_sensor_table_linearizer verification clean");
		else
			$display("smoothed_sensor_table_linearizer verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#(LIMIT_TIME);
		$display("smoothed_sensor_table_linearizer verification failed");
		$finish;
	end

endmodule
